// ----- hdl/tjc_pkg.sv -----
package tjc_pkg;

  localparam int SCALE_W = 12;
  localparam int DIST_W  = 14;
  localparam int OFS_W   = 12;
  localparam int CELL_W  = 8;
  localparam int VIS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam int BLOCKED = 9999;
  localparam int NEAR_MM = 300;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd1500;
  localparam logic [DIST_W-1:0]  FREE_RESET  = 14'd1200;
  localparam logic [1:0]         HEAD_RESET  = 2'd0;

  localparam logic [1:0] REG_SCALE   = 2'd0;
  localparam logic [1:0] REG_FREE    = 2'd1;
  localparam logic [1:0] REG_HEADING = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_KEEP  = 3'd1;
  localparam logic [2:0] ACT_LEFT  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;
  localparam logic [2:0] ACT_BACK  = 3'd4;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIST_W-1:0]  free_path;
    logic               heading_wr;
  } cfg_t;

endpackage

// ----- hdl/tremaux_junction_chooser.sv -----
// Each item runs through the states CALC and RD_S, then RD_L and RD_R only when neighbor
// counts are needed, then DEC, which holds while an earlier result waits for the receiver.
// The result is registered on leaving DEC, and no new item is taken until the block is
// back in IDLE. The single read port of the visit count memory sets this order: the cell
// and up to three neighbor counts are read in turn, then the count is written back. After
// reset the GRID_SIDE*GRID_SIDE counts are cleared, one a cycle, before any item is taken.
module tremaux_junction_chooser #(
  parameter int GRID_SIDE  = 32,
  parameter int COUNT_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tjc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tjc_pkg::DATA_W-1:0]  pwdata,
  output logic [tjc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic signed [7:0]           cell_x,
  input  logic signed [7:0]           cell_y,
  input  logic signed [11:0]          offset_x,
  input  logic signed [11:0]          offset_y,
  input  logic [13:0]                 front_mm,
  input  logic [13:0]                 left_mm,
  input  logic [13:0]                 right_mm,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [2:0]                  action,
  output logic [1:0]                  heading,
  output logic [7:0]                  visits_here
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int XB    = $clog2(GRID_SIDE);
  localparam int AB    = $clog2(CELLS);
  localparam int CB    = COUNT_BITS;
  localparam int VB    = (COUNT_BITS > 14) ? COUNT_BITS : 14;
  localparam int VW    = tjc_pkg::VIS_W;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CALC  = 7'b0000100,
    ST_RD_S  = 7'b0001000,
    ST_RD_L  = 7'b0010000,
    ST_RD_R  = 7'b0100000,
    ST_DEC   = 7'b1000000
  } state_t;

  function automatic logic [256*XB-1:0] wrap_table();
    logic [256*XB-1:0] t;
    int v;
    int w;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      v = (i < 128) ? i : i - 256;
      w = ((v % GRID_SIDE) + GRID_SIDE) % GRID_SIDE;
      t[i*XB +: XB] = XB'(w);
    end
    return t;
  endfunction

  localparam logic [256*XB-1:0] WRAP_TAB = wrap_table();

  function automatic logic [AB-1:0] cell_addr(input logic [XB-1:0] x, input logic [XB-1:0] y);
    return AB'(AB'(x) * AB'(GRID_SIDE) + AB'(y));
  endfunction

  function automatic logic [VW-1:0] clip_vis(input logic [CB-1:0] c);
    logic [CB+VW-1:0] e;
    e = (CB+VW)'(c);
    return (e > (CB+VW)'(255)) ? 8'hFF : e[VW-1:0];
  endfunction

  tjc_pkg::cfg_t cfg;

  tjc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state;
  logic [AB-1:0] clr_addr;

  logic signed [7:0]  cx_q;
  logic signed [7:0]  cy_q;
  logic signed [11:0] ox_q;
  logic signed [11:0] oy_q;
  logic [13:0]        df_q;
  logic [13:0]        dl_q;
  logic [13:0]        dr_q;

  logic [1:0]        target_heading;
  logic              cell_done;
  logic signed [7:0] prev_cell_x;
  logic signed [7:0] prev_cell_y;
  logic              tracking_valid;

  logic [AB-1:0] addr_here;
  logic [AB-1:0] addr_s;
  logic [AB-1:0] addr_l;
  logic [AB-1:0] addr_r;
  logic          eval;
  logic          open_s;
  logic          open_l;
  logic          open_r;
  logic          need_nb;
  logic [CB-1:0] cnt_here;
  logic [CB-1:0] cnt_s;
  logic [CB-1:0] cnt_l;

  logic          ram_we;
  logic [AB-1:0] ram_waddr;
  logic [CB-1:0] ram_wdata;
  logic [AB-1:0] ram_raddr;
  logic [CB-1:0] ram_rdata;

  tjc_ram #(
    .WIDTH (CB),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cell tracking, neighbor addresses and the open tests, from the stored item.
  logic [XB-1:0]        wx;
  logic [XB-1:0]        wy;
  logic [XB-1:0]        xp;
  logic [XB-1:0]        xm;
  logic [XB-1:0]        yp;
  logic [XB-1:0]        ym;
  logic [AB-1:0]        dir_addr [4];
  logic signed [12:0]   along;
  logic                 near;
  logic                 moved;
  logic                 done_eff;
  logic                 zero_scale;
  logic                 open_s_c;
  logic                 open_l_c;
  logic                 open_r_c;
  logic signed [15:0]   ahead;

  always_comb begin
    wx = WRAP_TAB[int'($unsigned(cx_q))*XB +: XB];
    wy = WRAP_TAB[int'($unsigned(cy_q))*XB +: XB];
    xp = (wx == XB'(GRID_SIDE-1)) ? '0 : wx + 1'b1;
    xm = (wx == '0) ? XB'(GRID_SIDE-1) : wx - 1'b1;
    yp = (wy == XB'(GRID_SIDE-1)) ? '0 : wy + 1'b1;
    ym = (wy == '0) ? XB'(GRID_SIDE-1) : wy - 1'b1;
    dir_addr[0] = cell_addr(xp, wy);
    dir_addr[1] = cell_addr(wx, yp);
    dir_addr[2] = cell_addr(xm, wy);
    dir_addr[3] = cell_addr(wx, ym);
    case (target_heading)
      2'd0:    along = 13'(ox_q);
      2'd1:    along = 13'(oy_q);
      2'd2:    along = -13'(ox_q);
      default: along = -13'(oy_q);
    endcase
    near = (along >= -13'sd300) ||
           ({1'b0, df_q, 1'b0} < 16'(cfg.scale) + 16'(2 * tjc_pkg::NEAR_MM));
    moved      = tracking_valid && ((cx_q != prev_cell_x) || (cy_q != prev_cell_y));
    done_eff   = cell_done && !moved;
    zero_scale = (cfg.scale == '0);
    ahead      = $signed({2'b00, df_q}) + 16'(along);
    open_s_c   = ahead > $signed({2'b00, cfg.free_path});
    open_l_c   = dl_q > cfg.free_path;
    open_r_c   = dr_q > cfg.free_path;
  end

  // Choice among the open neighbors.
  logic [VB-1:0] vs;
  logic [VB-1:0] vl;
  logic [VB-1:0] vr;
  logic [VB-1:0] mn;
  logic [2:0]    act_c;
  logic [1:0]    head_c;
  logic [CB-1:0] cnt_inc;
  logic          out_free;

  always_comb begin
    vs = open_s ? VB'(cnt_s) : VB'(tjc_pkg::BLOCKED);
    vl = open_l ? VB'(cnt_l) : VB'(tjc_pkg::BLOCKED);
    vr = open_r ? VB'(ram_rdata) : VB'(tjc_pkg::BLOCKED);
    mn = vs;
    if (vl < mn) begin
      mn = vl;
    end
    if (vr < mn) begin
      mn = vr;
    end
    act_c  = tjc_pkg::ACT_NONE;
    head_c = target_heading;
    if (eval) begin
      if (!need_nb) begin
        act_c = tjc_pkg::ACT_KEEP;
      end else if (mn < VB'(tjc_pkg::BLOCKED)) begin
        if (vs == mn) begin
          act_c = tjc_pkg::ACT_KEEP;
        end else if (vl == mn) begin
          act_c  = tjc_pkg::ACT_LEFT;
          head_c = target_heading + 2'd1;
        end else begin
          act_c  = tjc_pkg::ACT_RIGHT;
          head_c = target_heading + 2'd3;
        end
      end else begin
        act_c  = tjc_pkg::ACT_BACK;
        head_c = target_heading + 2'd2;
      end
    end
    cnt_inc  = (cnt_here == '1) ? cnt_here : cnt_here + 1'b1;
    out_free = !result_valid || result_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_here;
    ram_wdata = cnt_inc;
    ram_raddr = addr_r;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_CALC: ram_raddr = cell_addr(wx, wy);
      ST_RD_S: ram_raddr = addr_s;
      ST_RD_L: ram_raddr = addr_l;
      ST_DEC:  ram_we    = eval && out_free;
      default: ;
    endcase
  end

  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      target_heading <= tjc_pkg::HEAD_RESET;
      cell_done      <= 1'b1;
      prev_cell_x    <= '0;
      prev_cell_y    <= '0;
      tracking_valid <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (state == ST_DEC && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg.heading_wr) begin
        target_heading <= pwdata[1:0];
      end else if (state == ST_DEC && out_free && eval) begin
        target_heading <= head_c;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AB'(CELLS-1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (!zero_scale) begin
            if (!tracking_valid) begin
              tracking_valid <= 1'b1;
              prev_cell_x    <= cx_q;
              prev_cell_y    <= cy_q;
            end else if (moved) begin
              cell_done   <= 1'b0;
              prev_cell_x <= cx_q;
              prev_cell_y <= cy_q;
            end
          end
          state <= ST_RD_S;
        end
        ST_RD_S: state <= need_nb ? ST_RD_L : ST_DEC;
        ST_RD_L: state <= ST_RD_R;
        ST_RD_R: state <= ST_DEC;
        ST_DEC: begin
          if (out_free) begin
            if (eval) begin
              cell_done <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cx_q <= cell_x;
      cy_q <= cell_y;
      ox_q <= offset_x;
      oy_q <= offset_y;
      df_q <= front_mm;
      dl_q <= left_mm;
      dr_q <= right_mm;
    end
    if (state == ST_CALC) begin
      addr_here <= cell_addr(wx, wy);
      addr_s    <= dir_addr[target_heading];
      addr_l    <= dir_addr[target_heading + 2'd1];
      addr_r    <= dir_addr[target_heading + 2'd3];
      eval      <= !zero_scale && near && !done_eff;
      need_nb   <= !zero_scale && near && !done_eff &&
                   !(open_s_c && !open_l_c && !open_r_c);
      open_s    <= open_s_c;
      open_l    <= open_l_c;
      open_r    <= open_r_c;
    end
    if (state == ST_RD_S) begin
      cnt_here <= ram_rdata;
    end
    if (state == ST_RD_L) begin
      cnt_s <= ram_rdata;
    end
    if (state == ST_RD_R) begin
      cnt_l <= ram_rdata;
    end
    if (state == ST_DEC && out_free) begin
      action      <= act_c;
      heading     <= head_c;
      visits_here <= clip_vis(eval ? cnt_inc : cnt_here);
    end
  end

endmodule

// ----- hdl/tjc_ram.sv -----
module tjc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tjc_cfg.sv -----
module tjc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tjc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tjc_pkg::DATA_W-1:0]  pwdata,
  output logic [tjc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tjc_pkg::cfg_t               cfg
);

  logic [tjc_pkg::SCALE_W-1:0] scale;
  logic [tjc_pkg::DIST_W-1:0]  free_path;
  logic [1:0]                  start_heading;
  logic                        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= tjc_pkg::SCALE_RESET;
      free_path     <= tjc_pkg::FREE_RESET;
      start_heading <= tjc_pkg::HEAD_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        tjc_pkg::REG_SCALE:   scale         <= pwdata[tjc_pkg::SCALE_W-1:0];
        tjc_pkg::REG_FREE:    free_path     <= pwdata[tjc_pkg::DIST_W-1:0];
        tjc_pkg::REG_HEADING: start_heading <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tjc_pkg::REG_SCALE:   prdata = tjc_pkg::DATA_W'(scale);
      tjc_pkg::REG_FREE:    prdata = tjc_pkg::DATA_W'(free_path);
      tjc_pkg::REG_HEADING: prdata = tjc_pkg::DATA_W'(start_heading);
      default:              prdata = '0;
    endcase
  end

  assign cfg.scale         = scale;
  assign cfg.free_path     = free_path;
  assign cfg.heading_wr    = wr && (paddr[3:2] == tjc_pkg::REG_HEADING);

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = 32;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 300;
  localparam int PHASES = 8;
  localparam logic [7:0] COUNT_TOP = 8'hFF;

  typedef struct packed {
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [11:0] ox;
    logic [11:0] oy;
    logic [13:0] df;
    logic [13:0] dl;
    logic [13:0] dr;
  } reading_t;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] hd;
    logic [7:0] vis;
  } move_t;

  typedef struct packed {
    reading_t rd;
    logic     typed;
    move_t    mv;
  } script_row_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [tjc_pkg::ADDR_W-1:0]   paddr;
  logic [tjc_pkg::DATA_W-1:0]   pwdata;
  logic [tjc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         item_valid;
  logic                         item_ready;
  logic signed [7:0]            cell_x;
  logic signed [7:0]            cell_y;
  logic signed [11:0]           offset_x;
  logic signed [11:0]           offset_y;
  logic [13:0]                  front_mm;
  logic [13:0]                  left_mm;
  logic [13:0]                  right_mm;
  logic                         result_valid;
  logic                         result_ready;
  logic [2:0]                   action;
  logic [1:0]                   heading;
  logic [7:0]                   visits_here;

  tremaux_junction_chooser #(
    .GRID_SIDE(GRID),
    .COUNT_BITS(8)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .front_mm(front_mm),
    .left_mm(left_mm),
    .right_mm(right_mm),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .action(action),
    .heading(heading),
    .visits_here(visits_here)
  );

  logic [7:0]                  visits [GRID*GRID];
  logic [1:0]                  tgt_heading;
  bit                          cell_settled;
  int                          last_cx;
  int                          last_cy;
  bit                          tracking;
  logic [tjc_pkg::SCALE_W-1:0] cfg_scale;
  logic [tjc_pkg::DIST_W-1:0]  cfg_free;

  move_t pending_moves [$];
  int    errors;
  int    results_seen;
  int    quiet_cycles;
  bit    gaps_on;
  bit    held;
  logic [7:0] walk_x;
  logic [7:0] walk_y;

  script_row_t opening_rows [16] = '{
    '{'{8'h00, 8'h00, 12'h000, 12'h000, 14'd10000, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h00, 8'h00, 12'h000, 12'h000, 14'd0, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h01, 8'h00, 12'h000, 12'h000, 14'd10000, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_KEEP, 2'd0, 8'd1}},
    '{'{8'h02, 8'h00, 12'h000, 12'h000, 14'd0, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_BACK, 2'd2, 8'd1}},
    '{'{8'h01, 8'h00, 12'h7FF, 12'h000, 14'd16383, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_NONE, 2'd2, 8'd1}},
    '{'{8'h01, 8'h00, 12'h000, 12'h000, 14'd0, 14'd0, 14'd0}, 1'b1,
      '{tjc_pkg::ACT_BACK, 2'd0, 8'd2}},
    '{'{8'h02, 8'h00, 12'h000, 12'h000, 14'd10000, 14'd10000, 14'd0}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h03, 8'h00, 12'h000, 12'h000, 14'd0, 14'd10000, 14'd10000}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h03, 8'h01, 12'h000, 12'h000, 14'd16383, 14'd16383, 14'd16383}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h03, 8'h02, 12'h000, 12'h800, 14'd100, 14'd0, 14'd5000}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h80, 8'h7F, 12'h800, 12'h7FF, 14'd16383, 14'd16383, 14'd16383}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h7F, 8'h80, 12'h7FF, 12'h800, 14'd0, 14'd16383, 14'd0}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'hFF, 8'h20, 12'h000, 12'h000, 14'd1200, 14'd1201, 14'd1200}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h1F, 8'hE0, 12'hED4, 12'hED4, 14'd1201, 14'd1200, 14'd1201}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h00, 8'h00, 12'hED3, 12'hED3, 14'd0, 14'd0, 14'd0}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}},
    '{'{8'h01, 8'h00, 12'hED3, 12'hED3, 14'd1050, 14'd0, 14'd0}, 1'b0,
      '{tjc_pkg::ACT_NONE, 2'd0, 8'd0}}
  };

  int phase_scale [PHASES] = '{1500, 600, 0, 4095, 4000, 1, 2000, 1500};
  int phase_free  [PHASES] = '{1200, 300, 5000, 16383, 0, 10000, 800, 1200};
  int phase_head  [PHASES] = '{1, 2, 3, 0, 2, 1, 3, 0};
  int phase_items [PHASES] = '{250, 600, 60, 150, 150, 150, 250, 250};

  function automatic int step_dx(logic [1:0] h);
    return h == 2'd0 ? 1 : (h == 2'd2 ? -1 : 0);
  endfunction

  function automatic int step_dy(logic [1:0] h);
    return h == 2'd1 ? 1 : (h == 2'd3 ? -1 : 0);
  endfunction

  function automatic int cell_at(int x, int y);
    int wx;
    int wy;
    wx = ((x % GRID) + GRID) % GRID;
    wy = ((y % GRID) + GRID) % GRID;
    return wx * GRID + wy;
  endfunction

  function automatic move_t choose_move(reading_t rd);
    move_t      mv;
    int         cx;
    int         cy;
    int         here;
    int         along;
    int         vs;
    int         vl;
    int         vr;
    int         mn;
    bit         near;
    bit         open_s;
    bit         open_l;
    bit         open_r;
    logic [1:0] h;
    logic [1:0] hl;
    logic [1:0] hr;
    logic [2:0] act;
    cx = int'($signed(rd.cx));
    cy = int'($signed(rd.cy));
    here = cell_at(cx, cy);
    h = tgt_heading;
    mv.act = tjc_pkg::ACT_NONE;
    mv.hd = h;
    mv.vis = visits[here];
    if (cfg_scale == '0) return mv;
    if (!tracking) begin
      last_cx = cx;
      last_cy = cy;
      tracking = 1'b1;
    end else if (cx != last_cx || cy != last_cy) begin
      cell_settled = 1'b0;
      last_cx = cx;
      last_cy = cy;
    end
    along = int'($signed(rd.ox)) * step_dx(h) + int'($signed(rd.oy)) * step_dy(h);
    near = along >= -tjc_pkg::NEAR_MM;
    if (2 * int'(rd.df) < int'(cfg_scale) + 2 * tjc_pkg::NEAR_MM) near = 1'b1;
    if (!near || cell_settled) return mv;
    open_s = int'(rd.df) + along > int'(cfg_free);
    open_l = int'(rd.dl) > int'(cfg_free);
    open_r = int'(rd.dr) > int'(cfg_free);
    if (open_s && !open_l && !open_r) begin
      act = tjc_pkg::ACT_KEEP;
    end else begin
      hl = h + 2'd1;
      hr = h + 2'd3;
      vs = open_s ? int'(visits[cell_at(cx + step_dx(h), cy + step_dy(h))]) :
                    tjc_pkg::BLOCKED;
      vl = open_l ? int'(visits[cell_at(cx + step_dx(hl), cy + step_dy(hl))]) :
                    tjc_pkg::BLOCKED;
      vr = open_r ? int'(visits[cell_at(cx + step_dx(hr), cy + step_dy(hr))]) :
                    tjc_pkg::BLOCKED;
      mn = vs;
      if (vl < mn) mn = vl;
      if (vr < mn) mn = vr;
      if (mn < tjc_pkg::BLOCKED) begin
        if (vs == mn) begin
          act = tjc_pkg::ACT_KEEP;
        end else if (vl == mn) begin
          act = tjc_pkg::ACT_LEFT;
          h = hl;
        end else begin
          act = tjc_pkg::ACT_RIGHT;
          h = hr;
        end
      end else begin
        act = tjc_pkg::ACT_BACK;
        h = h + 2'd2;
      end
    end
    tgt_heading = h;
    cell_settled = 1'b1;
    if (visits[here] != COUNT_TOP) visits[here] = visits[here] + 8'd1;
    mv.act = act;
    mv.hd = h;
    mv.vis = visits[here];
    return mv;
  endfunction

  function automatic logic [13:0] pick_dist(int fp);
    int top;
    top = fp + 4000;
    if (top > 16383) top = 16383;
    case ($urandom_range(0, 4))
      0: return 14'($urandom_range(0, fp));
      1: return 14'($urandom_range(fp < 16383 ? fp + 1 : 16383, top));
      2: return 14'($urandom);
      3: return 14'(fp + int'($urandom_range(0, 1)));
      default: return 14'($urandom_range(0, 10000));
    endcase
  endfunction

  function automatic logic [7:0] rim_coord();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'hFF;
      3: return 8'h1F;
      4: return 8'h20;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [11:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 12'($urandom);
      1: return 12'(int'($urandom_range(0, 4000)) - 2000);
      default: return 12'(int'($urandom_range(0, 700)) - 350);
    endcase
  endfunction

  // Most readings follow a robot walking cell to cell along its current heading,
  // so that decisions and neighbor counts come into play; the rest is noise.
  function automatic reading_t make_reading(bit ping_pong, int k);
    reading_t   rd;
    int         fp;
    logic [1:0] h;
    fp = int'(cfg_free);
    if (ping_pong) begin
      rd.cx = 8'd3;
      rd.cy = (k % 2 == 1) ? 8'd4 : 8'd3;
      rd.ox = '0;
      rd.oy = '0;
    end else if ($urandom_range(0, 15) == 0) begin
      rd.cx = 8'($urandom);
      rd.cy = 8'($urandom);
      rd.ox = 12'($urandom);
      rd.oy = 12'($urandom);
      rd.df = 14'($urandom);
      rd.dl = 14'($urandom);
      rd.dr = 14'($urandom);
      return rd;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          h = ($urandom_range(0, 5) == 0) ? 2'($urandom) : tgt_heading;
          rd.cx = 8'(int'($signed(walk_x)) + step_dx(h));
          rd.cy = 8'(int'($signed(walk_y)) + step_dy(h));
        end
        6, 7: begin
          rd.cx = walk_x;
          rd.cy = walk_y;
        end
        8: begin
          rd.cx = 8'($urandom_range(0, 6));
          rd.cy = 8'($urandom_range(0, 6));
        end
        default: begin
          rd.cx = rim_coord();
          rd.cy = rim_coord();
        end
      endcase
      rd.ox = pick_offset();
      rd.oy = pick_offset();
    end
    walk_x = rd.cx;
    walk_y = rd.cy;
    rd.df = pick_dist(fp);
    rd.dl = pick_dist(fp);
    rd.dr = pick_dist(fp);
    return rd;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [tjc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tjc_pkg::REG_SCALE: cfg_scale = val[tjc_pkg::SCALE_W-1:0];
      tjc_pkg::REG_FREE: cfg_free = val[tjc_pkg::DIST_W-1:0];
      tjc_pkg::REG_HEADING: tgt_heading = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_reading(reading_t rd, bit typed, move_t typed_mv);
    int    n;
    move_t mv;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 16);
      item_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    cell_x = rd.cx;
    cell_y = rd.cy;
    offset_x = rd.ox;
    offset_y = rd.oy;
    front_mm = rd.df;
    left_mm = rd.dl;
    right_mm = rd.dr;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    mv = choose_move(rd);
    if (typed) mv = typed_mv;
    pending_moves = {pending_moves, mv};
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    cell_x = '0;
    cell_y = '0;
    offset_x = '0;
    offset_y = '0;
    front_mm = '0;
    left_mm = '0;
    right_mm = '0;
    for (int i = 0; i < GRID * GRID; i++) visits[i] = 8'd0;
    cfg_scale = tjc_pkg::SCALE_RESET;
    cfg_free = tjc_pkg::FREE_RESET;
    tgt_heading = tjc_pkg::HEAD_RESET;
    cell_settled = 1'b1;
    tracking = 1'b0;
    last_cx = 0;
    last_cy = 0;
    walk_x = '0;
    walk_y = '0;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_rows[i])
      send_reading(opening_rows[i].rd, opening_rows[i].typed, opening_rows[i].mv);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) gaps_on = 1'b0;
      write_reg(tjc_pkg::REG_SCALE, tjc_pkg::DATA_W'(phase_scale[p]));
      write_reg(tjc_pkg::REG_FREE, tjc_pkg::DATA_W'(phase_free[p]));
      write_reg(tjc_pkg::REG_HEADING, tjc_pkg::DATA_W'(phase_head[p]));
      for (int k = 0; k < phase_items[p]; k++)
        send_reading(make_reading(p == 1, k), 1'b0, '0);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tremaux_junction_chooser test passed");
    end else begin
      $display("tremaux_junction_chooser test failed");
    end
    $finish;
  end

  initial begin : receiver
    int n;
    result_ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_ready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 16);
        result_ready = 1'b0;
        repeat (n) @(negedge clk);
        result_ready = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(20, 60);
        result_ready = 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin : check_results
    move_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_moves.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: action %0d heading %0d visits %0d",
                   action, heading, visits_here);
      end else begin
        want = pending_moves.pop_front();
        if (action !== want.act || heading !== want.hd || visits_here !== want.vis) begin
          errors++;
          if (errors <= 10)
            $display("result %0d mismatch: action %0d/%0d heading %0d/%0d visits %0d/%0d",
                     results_seen, want.act, action, want.hd, heading, want.vis,
                     visits_here);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tremaux_junction_chooser test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- tremaux_junction_chooser.f -----
hdl/tjc_pkg.sv
hdl/tjc_ram.sv
hdl/tjc_cfg.sv
hdl/tremaux_junction_chooser.sv
bench/tb.sv
